// File: hdl/cdte_pkg.sv
// Shared types, constants and lookup functions for the date to epoch seconds unit.
package cdte_pkg;

    localparam int unsigned MAX_YEAR_DEF = 9999;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned TS_W    = 38;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 40;

    // seconds of day < 86400, day count up to year 9999 < 2^22
    localparam int unsigned SOD_W  = 17;
    localparam int unsigned DAYS_W = 22;
    localparam int unsigned YOFF_W = 13;
    localparam int unsigned LEAP_W = 12;
    localparam int unsigned YDAY_W = 9;

    // n / 100 for n < 2^14 as (n * 5243) >> 19
    localparam int unsigned DIV_PROD_W = 27;
    localparam int unsigned DIV_SHIFT  = 19;
    localparam int unsigned QUOT_W     = DIV_PROD_W - DIV_SHIFT;
    localparam logic [DIV_PROD_W-1:0] DIV100_MUL = DIV_PROD_W'(5243);

    localparam logic [YEAR_W-1:0] EPOCH_YEAR     = YEAR_W'(1970);
    localparam logic [LEAP_W-1:0] LEAPS_TO_EPOCH = LEAP_W'(477);

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
    localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);
    localparam logic [SEC_W-1:0]  SEC_MAX  = SEC_W'(59);

    localparam logic [SOD_W-1:0]  SECS_PER_HOUR = SOD_W'(3600);
    localparam logic [SOD_W-1:0]  SECS_PER_MIN  = SOD_W'(60);
    localparam logic [TS_W-1:0]   SECS_PER_DAY  = TS_W'(86400);
    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = DAYS_W'(365);

    // stage 3 -> stage 4
    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
    } day_t;

    // output register contents
    typedef struct packed {
        logic            valid;
        logic            ok;
        logic [TS_W-1:0] ts;
    } res_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = DAY_W'(30);
            default: len = DAY_W'(31);
        endcase
        return len;
    endfunction

    function automatic logic [YDAY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [YDAY_W-1:0] d;
        case (m)
            4'd1:    d = YDAY_W'(0);
            4'd2:    d = YDAY_W'(31);
            4'd3:    d = YDAY_W'(59);
            4'd4:    d = YDAY_W'(90);
            4'd5:    d = YDAY_W'(120);
            4'd6:    d = YDAY_W'(151);
            4'd7:    d = YDAY_W'(181);
            4'd8:    d = YDAY_W'(212);
            4'd9:    d = YDAY_W'(243);
            4'd10:   d = YDAY_W'(273);
            4'd11:   d = YDAY_W'(304);
            4'd12:   d = YDAY_W'(334);
            default: d = YDAY_W'(0);
        endcase
        return d;
    endfunction

endpackage

// File: hdl/cdte_day_count.sv
// Stages 1 to 3: range checks, leap-year logic and whole-day count since the epoch.
module cdte_day_count #(
    parameter int unsigned MAX_YEAR = cdte_pkg::MAX_YEAR_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [cdte_pkg::YEAR_W-1:0]  year,
    input  logic [cdte_pkg::MONTH_W-1:0] month,
    input  logic [cdte_pkg::DAY_W-1:0]   day,
    input  logic [cdte_pkg::HOUR_W-1:0]  hour,
    input  logic [cdte_pkg::MIN_W-1:0]   minute,
    input  logic [cdte_pkg::SEC_W-1:0]   second,
    output cdte_pkg::day_t               day_out
);

    localparam logic [cdte_pkg::YEAR_W-1:0] LAST_YEAR = cdte_pkg::YEAR_W'(MAX_YEAR);

    // stage 1
    logic                                v1_reg;
    logic                                ok1_reg, ok1_next;
    logic [cdte_pkg::YEAR_W-1:0]         year1_reg;
    logic [cdte_pkg::MONTH_W-1:0]        month1_reg;
    logic [cdte_pkg::DAY_W-1:0]          day1_reg;
    logic [cdte_pkg::SOD_W-1:0]          sod1_reg, sod1_next;
    logic [cdte_pkg::DIV_PROD_W-1:0]     prod_prev1_reg, prod_prev1_next;
    logic [cdte_pkg::DIV_PROD_W-1:0]     prod_cur1_reg, prod_cur1_next;
    logic [cdte_pkg::YEAR_W-1:0]         year_prev;

    // stage 2
    logic                                v2_reg;
    logic                                ok2_reg, ok2_next;
    logic [cdte_pkg::YOFF_W-1:0]         yoff2_reg, yoff2_next;
    logic [cdte_pkg::LEAP_W-1:0]         leaps2_reg, leaps2_next;
    logic [cdte_pkg::YDAY_W-1:0]         yday2_reg, yday2_next;
    logic [cdte_pkg::SOD_W-1:0]          sod2_reg;
    logic [cdte_pkg::QUOT_W-1:0]         q_prev, q_cur;
    logic [cdte_pkg::YEAR_W-1:0]         cent_year;
    logic [cdte_pkg::YEAR_W-1:0]         year_prev1;
    logic                                leap;

    // stage 3
    logic                                v3_reg;
    logic                                ok3_reg;
    logic [cdte_pkg::DAYS_W-1:0]         days3_reg, days3_next;
    logic [cdte_pkg::SOD_W-1:0]          sod3_reg;

    // ---- stage 1: checks, time of day, reciprocal multiplies for /100
    assign year_prev = year - cdte_pkg::YEAR_W'(1);

    always_comb
    begin
        ok1_next = (year >= cdte_pkg::EPOCH_YEAR) && (year <= LAST_YEAR)
                && (month >= cdte_pkg::MONTH_JAN) && (month <= cdte_pkg::MONTH_DEC)
                && (day != '0)
                && (hour <= cdte_pkg::HOUR_MAX) && (minute <= cdte_pkg::MIN_MAX)
                && (second <= cdte_pkg::SEC_MAX);
        sod1_next = cdte_pkg::SOD_W'(hour) * cdte_pkg::SECS_PER_HOUR
                  + cdte_pkg::SOD_W'(minute) * cdte_pkg::SECS_PER_MIN
                  + cdte_pkg::SOD_W'(second);
        prod_prev1_next = cdte_pkg::DIV_PROD_W'(year_prev) * cdte_pkg::DIV100_MUL;
        prod_cur1_next  = cdte_pkg::DIV_PROD_W'(year) * cdte_pkg::DIV100_MUL;
    end

    // ---- stage 2: leap year, month length check, day of year, leap count
    assign q_prev     = prod_prev1_reg[cdte_pkg::DIV_PROD_W-1:cdte_pkg::DIV_SHIFT];
    assign q_cur      = prod_cur1_reg[cdte_pkg::DIV_PROD_W-1:cdte_pkg::DIV_SHIFT];
    assign cent_year  = cdte_pkg::YEAR_W'(q_cur) * cdte_pkg::YEAR_W'(100);
    assign year_prev1 = year1_reg - cdte_pkg::YEAR_W'(1);

    always_comb
    begin
        // divisible by 4 and not a century, or a century divisible by 400
        leap = ((year1_reg[1:0] == 2'b00) && (cent_year != year1_reg))
            || ((cent_year == year1_reg) && (q_cur[1:0] == 2'b00));
        ok2_next = ok1_reg
                && (day1_reg <= cdte_pkg::month_len(month1_reg, leap));
        yday2_next = cdte_pkg::days_before_month(month1_reg)
                   + cdte_pkg::YDAY_W'(leap && (month1_reg > cdte_pkg::MONTH_FEB))
                   + cdte_pkg::YDAY_W'(day1_reg) - cdte_pkg::YDAY_W'(1);
        // leaps in 1970..year-1
        leaps2_next = cdte_pkg::LEAP_W'(year_prev1 >> 2)
                    - cdte_pkg::LEAP_W'(q_prev)
                    + cdte_pkg::LEAP_W'(q_prev >> 2)
                    - cdte_pkg::LEAPS_TO_EPOCH;
        yoff2_next = cdte_pkg::YOFF_W'(year1_reg - cdte_pkg::EPOCH_YEAR);
    end

    // ---- stage 3: whole days since the epoch
    assign days3_next = cdte_pkg::DAYS_W'(yoff2_reg) * cdte_pkg::DAYS_PER_YEAR
                      + cdte_pkg::DAYS_W'(leaps2_reg)
                      + cdte_pkg::DAYS_W'(yday2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok1_reg        <= ok1_next;
            year1_reg      <= year;
            month1_reg     <= month;
            day1_reg       <= day;
            sod1_reg       <= sod1_next;
            prod_prev1_reg <= prod_prev1_next;
            prod_cur1_reg  <= prod_cur1_next;

            ok2_reg        <= ok2_next;
            yoff2_reg      <= yoff2_next;
            leaps2_reg     <= leaps2_next;
            yday2_reg      <= yday2_next;
            sod2_reg       <= sod1_reg;

            ok3_reg        <= ok2_reg;
            days3_reg      <= days3_next;
            sod3_reg       <= sod2_reg;
        end
    end

    assign day_out.valid = v3_reg;
    assign day_out.ok    = ok3_reg;
    assign day_out.days  = days3_reg;
    assign day_out.sod   = sod3_reg;

endmodule

// File: hdl/cdte_sec_calc.sv
// Stage 4: days times 86400 plus seconds of day into the output register.
module cdte_sec_calc (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  cdte_pkg::day_t day_in,
    output cdte_pkg::res_t res_out
);

    logic                        valid_reg;
    logic                        ok_reg;
    logic [cdte_pkg::TS_W-1:0]   ts_reg, ts_next;

    // rejected items leave as zero
    assign ts_next = day_in.ok
                   ? cdte_pkg::TS_W'(day_in.days) * cdte_pkg::SECS_PER_DAY
                     + cdte_pkg::TS_W'(day_in.sod)
                   : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= day_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_reg <= day_in.ok;
            ts_reg <= ts_next;
        end
    end

    assign res_out.valid = valid_reg;
    assign res_out.ok    = ok_reg;
    assign res_out.ts    = ts_reg;

endmodule

// File: hdl/civil_date_to_epoch_seconds_unit.sv
// Top level: UTC calendar date and time in, Unix timestamp out, four-stage pipeline.
//
// Converts one Gregorian UTC date and time per transfer into seconds since
// 1970-01-01 00:00:00. One transfer can be taken every clock cycle unless the pipeline
// holds; each result passes the stages in order (range checks and the divide-by-100
// reciprocal multiplies, leap and day-of-year logic, the day count, then the
// seconds multiply into the output register). The whole pipeline holds while a
// result waits on m_axis_tready. Years outside 1970..MAX_YEAR, bad months, days
// past the month length or out-of-range times give timestamp 0 with tuser low.
module civil_date_to_epoch_seconds_unit #(
    parameter int unsigned MAX_YEAR = cdte_pkg::MAX_YEAR_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], second[39:34]
    input  logic [cdte_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // timestamp[37:0], zero pad[39:38]
    output logic [cdte_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // valid_res[0]
    output logic                               m_axis_tuser
);

    logic           advance;
    cdte_pkg::day_t day_s;
    cdte_pkg::res_t res_s;

    // all stages move together; an empty output register never blocks
    assign advance       = !res_s.valid || m_axis_tready;
    assign s_axis_tready = advance;

    cdte_day_count #(
        .MAX_YEAR (MAX_YEAR)
    ) u_day_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (s_axis_tvalid),
        .year     (s_axis_tdata[13:0]),
        .month    (s_axis_tdata[17:14]),
        .day      (s_axis_tdata[22:18]),
        .hour     (s_axis_tdata[27:23]),
        .minute   (s_axis_tdata[33:28]),
        .second   (s_axis_tdata[39:34]),
        .day_out  (day_s)
    );

    cdte_sec_calc u_sec_calc (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .day_in  (day_s),
        .res_out (res_s)
    );

    assign m_axis_tvalid = res_s.valid;
    assign m_axis_tdata  = cdte_pkg::OUT_DATA_W'(res_s.ts);
    assign m_axis_tuser  = res_s.ok;

endmodule

// File: sim/civil_date_to_epoch_seconds_unit_tb.sv
// Self-checking testbench for the date and time to epoch seconds unit.
`timescale 1ns / 100ps

module civil_date_to_epoch_seconds_unit_tb;

    localparam int unsigned LAST_YEAR   = cdte_pkg::MAX_YEAR_DEF;
    localparam int unsigned FIRST_YEAR  = 1970;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_TAIL  = 16;

    // packed to match s_axis_tdata, year in the low bits
    typedef struct packed {
        logic [cdte_pkg::SEC_W-1:0]   second;
        logic [cdte_pkg::MIN_W-1:0]   minute;
        logic [cdte_pkg::HOUR_W-1:0]  hour;
        logic [cdte_pkg::DAY_W-1:0]   day;
        logic [cdte_pkg::MONTH_W-1:0] month;
        logic [cdte_pkg::YEAR_W-1:0]  year;
    } date_t;

    typedef struct packed {
        logic [cdte_pkg::TS_W-1:0] timestamp;
        logic                      valid_res;
    } stamp_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [cdte_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [cdte_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;

    date_t  pending_dates[$];
    stamp_t expected_stamps[$];
    date_t  offered_date;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_requests;
    int unsigned holds_served;
    int unsigned hold_left;
    int unsigned stall_cycles;
    int unsigned error_count;

    civil_date_to_epoch_seconds_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic logic is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned leaps_up_to(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = is_leap(y) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    function automatic int unsigned days_ahead_of_month(input int unsigned m);
        int unsigned cum;
        int unsigned k;
        cum = 0;
        for (k = 1; k < m; k++)
            cum += month_days(1971, k);
        return cum;
    endfunction

    function automatic stamp_t civil_to_stamp(input date_t d);
        stamp_t          r;
        longint unsigned days;
        longint unsigned secs;
        int unsigned     y;
        int unsigned     m;
        r = '0;
        y = d.year;
        m = d.month;
        if (y < FIRST_YEAR || y > LAST_YEAR)
            return r;
        if (m < 1 || m > 12 || d.day == 0)
            return r;
        if (d.hour > 23 || d.minute > 59 || d.second > 59)
            return r;
        if (d.day > month_days(y, m))
            return r;
        days = longint'(365) * (y - FIRST_YEAR)
             + leaps_up_to(y - 1) - leaps_up_to(FIRST_YEAR - 1)
             + days_ahead_of_month(m) + d.day - 1;
        // Feb 29 already sits in the year when past February
        if (is_leap(y) && m > 2)
            days += 1;
        secs = days * 86400 + longint'(d.hour) * 3600 + longint'(d.minute) * 60
             + longint'(d.second);
        r.timestamp = secs[cdte_pkg::TS_W-1:0];
        r.valid_res = 1'b1;
        return r;
    endfunction

    function automatic date_t random_date();
        date_t       d;
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            // any bit pattern the fields allow
            d.year   = cdte_pkg::YEAR_W'($urandom_range(16383));
            d.month  = cdte_pkg::MONTH_W'($urandom_range(15));
            d.day    = cdte_pkg::DAY_W'($urandom_range(31));
            d.hour   = cdte_pkg::HOUR_W'($urandom_range(31));
            d.minute = cdte_pkg::MIN_W'($urandom_range(63));
            d.second = cdte_pkg::SEC_W'($urandom_range(63));
            return d;
        end
        case ($urandom_range(9))
            0:       d.year = cdte_pkg::YEAR_W'(FIRST_YEAR);
            1:       d.year = cdte_pkg::YEAR_W'(LAST_YEAR);
            2:       d.year = cdte_pkg::YEAR_W'($urandom_range(24, 20) * 100);
            3:       d.year = cdte_pkg::YEAR_W'($urandom_range(2104, 2096));
            default: d.year = cdte_pkg::YEAR_W'($urandom_range(LAST_YEAR, FIRST_YEAR));
        endcase
        d.month  = cdte_pkg::MONTH_W'($urandom_range(12, 1));
        len      = month_days(d.year, d.month);
        d.day    = ($urandom_range(3) == 0) ? cdte_pkg::DAY_W'(len)
                                            : cdte_pkg::DAY_W'($urandom_range(len, 1));
        d.hour   = cdte_pkg::HOUR_W'($urandom_range(23));
        d.minute = cdte_pkg::MIN_W'($urandom_range(59));
        d.second = cdte_pkg::SEC_W'($urandom_range(59));
        if (pick < 32)
        begin
            // well-formed but for one field
            case ($urandom_range(5))
                0: d.year = $urandom_range(1)
                          ? cdte_pkg::YEAR_W'($urandom_range(FIRST_YEAR - 1))
                          : cdte_pkg::YEAR_W'($urandom_range(16383, LAST_YEAR + 1));
                1: d.month = $urandom_range(1) ? cdte_pkg::MONTH_W'(0)
                                               : cdte_pkg::MONTH_W'($urandom_range(15, 13));
                2: d.day = $urandom_range(1) ? cdte_pkg::DAY_W'(0)
                                             : cdte_pkg::DAY_W'(len + 1);
                3: d.hour = cdte_pkg::HOUR_W'($urandom_range(31, 24));
                4: d.minute = cdte_pkg::MIN_W'($urandom_range(63, 60));
                default: d.second = cdte_pkg::SEC_W'($urandom_range(63, 60));
            endcase
        end
        return d;
    endfunction

    task automatic add_date(input int unsigned y, input int unsigned mo, input int unsigned d,
                            input int unsigned h, input int unsigned mi, input int unsigned s);
        date_t n;
        n.year   = cdte_pkg::YEAR_W'(y);
        n.month  = cdte_pkg::MONTH_W'(mo);
        n.day    = cdte_pkg::DAY_W'(d);
        n.hour   = cdte_pkg::HOUR_W'(h);
        n.minute = cdte_pkg::MIN_W'(mi);
        n.second = cdte_pkg::SEC_W'(s);
        pending_dates.push_back(n);
    endtask

    task automatic add_random(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++)
            pending_dates.push_back(random_date());
    endtask

    task automatic wait_drained();
        while (pending_dates.size() != 0 || s_axis_tvalid || expected_stamps.size() != 0)
            @(negedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive
        date_t next_date;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_stamps.push_back(civil_to_stamp(offered_date));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_dates.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_date     = pending_dates.pop_front();
                    offered_date  = next_date;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_date;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            holds_served  = 0;
            hold_left     = 0;
        end
        else
        begin
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left     = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin : check
        stamp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_stamps.size() == 0)
            begin
                $error("result transfer with nothing expected: timestamp %0d valid_res %0b",
                       m_axis_tdata[cdte_pkg::TS_W-1:0], m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = expected_stamps.pop_front();
                if (m_axis_tdata[cdte_pkg::TS_W-1:0] !== want.timestamp)
                begin
                    $error("timestamp: expected %0d, got %0d",
                           want.timestamp, m_axis_tdata[cdte_pkg::TS_W-1:0]);
                    error_count++;
                end
                if (m_axis_tuser !== want.valid_res)
                begin
                    $error("valid_res: expected %0b, got %0b", want.valid_res, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL civil_date_to_epoch_seconds_unit");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 38;
        hold_requests = 0;
        stall_cycles  = 0;
        error_count   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: range edges, leap rules, each kind of rejection
        add_date(1970, 1, 1, 0, 0, 0);
        add_date(9999, 12, 31, 23, 59, 59);
        add_date(1969, 12, 31, 23, 59, 59);
        add_date(10000, 1, 1, 0, 0, 0);
        add_date(0, 0, 0, 0, 0, 0);
        add_date(16383, 15, 31, 31, 63, 63);
        add_date(2000, 0, 10, 12, 0, 0);
        add_date(2000, 13, 10, 12, 0, 0);
        add_date(2000, 15, 10, 12, 0, 0);
        add_date(2000, 6, 0, 12, 0, 0);
        add_date(2001, 4, 31, 12, 0, 0);
        add_date(2000, 2, 29, 6, 30, 15);
        add_date(2100, 2, 29, 6, 30, 15);
        add_date(2400, 2, 29, 6, 30, 15);
        add_date(2023, 2, 29, 0, 0, 0);
        add_date(2024, 2, 30, 0, 0, 0);
        add_date(2024, 3, 1, 0, 0, 0);
        add_date(2023, 3, 1, 0, 0, 0);
        add_date(2024, 12, 31, 23, 59, 59);
        add_date(2030, 7, 4, 24, 0, 0);
        add_date(2030, 7, 4, 31, 0, 0);
        add_date(2030, 7, 4, 0, 60, 0);
        add_date(2030, 7, 4, 0, 63, 0);
        add_date(2030, 7, 4, 0, 0, 60);
        add_date(2038, 1, 19, 3, 14, 8);
        wait_drained();

        // receiver holds off while the sender keeps offering
        @(negedge clk);
        add_random(600);
        hold_requests = hold_requests + 1;
        wait_drained();

        // back to back, no idling either side
        @(negedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(500);
        wait_drained();

        @(negedge clk);
        send_idle_pct = 38;
        recv_idle_pct = 38;
        add_random(750);
        wait_drained();

        repeat (DRAIN_TAIL) @(negedge clk);
        if (error_count == 0)
            $display("PASS civil_date_to_epoch_seconds_unit");
        else
            $display("FAIL civil_date_to_epoch_seconds_unit");
        $finish;
    end

endmodule

// File: sim.f
hdl/cdte_pkg.sv
hdl/cdte_day_count.sv
hdl/cdte_sec_calc.sv
hdl/civil_date_to_epoch_seconds_unit.sv
sim/civil_date_to_epoch_seconds_unit_tb.sv
